### hw/rtl/lookahead_waypoint_tracker_top_defines.svh
// assertion macros shared by the waypoint tracker rtl
// no dependencies
`ifndef LOOKAHEAD_WAYPOINT_TRACKER_TOP_DEFINES_SVH
`define LOOKAHEAD_WAYPOINT_TRACKER_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define LWT_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define LWT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

### hw/rtl/lwt_pkg.sv
// constants, types and tables for the waypoint tracker
// no dependencies
`timescale 1ns / 1ps

package lwt_pkg;

   localparam int TableDepth = 128;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CordicSteps = 16;
   localparam int StepW = $clog2(CordicSteps);

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic signed [23:0] PI_Q20 = 24'sd3294199;
   localparam logic signed [17:0] PI_Q13 = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

   // arctangent table, Q.20 radians
   function automatic logic signed [23:0] atan_q20(input logic [StepW-1:0] i);
      logic signed [23:0] r;
      case (i)
         4'd0: r = 24'sd823550;
         4'd1: r = 24'sd486170;
         4'd2: r = 24'sd256879;
         4'd3: r = 24'sd130396;
         4'd4: r = 24'sd65451;
         4'd5: r = 24'sd32757;
         4'd6: r = 24'sd16383;
         4'd7: r = 24'sd8192;
         4'd8: r = 24'sd4096;
         4'd9: r = 24'sd2048;
         4'd10: r = 24'sd1024;
         4'd11: r = 24'sd512;
         4'd12: r = 24'sd256;
         4'd13: r = 24'sd128;
         4'd14: r = 24'sd64;
         default: r = 24'sd32;
      endcase
      return r;
   endfunction

   // cordic unit control
   typedef struct packed {
      logic start;
      logic signed [24:0] num;
      logic signed [24:0] den;
   } cordic_req_type;

   typedef struct packed {
      logic done;
      logic signed [15:0] angle;
   } cordic_rsp_type;

endpackage

### hw/rtl/lookahead_waypoint_tracker_top.sv
// waypoint tracker top: waypoint memory, sequencer, output register
// depends on lwt_pkg, lwt_cordic and the defines header
`timescale 1ns / 1ps
`include "lookahead_waypoint_tracker_top_defines.svh"
// Usage:
// A command beat is taken when start is high and busy is low; busy then
// stays high until the one result beat is shown on rsp_* with done high
// for one cycle. The receiver cannot stall.
// opcode 0 (position update) reads the waypoint memory from the nearest
// pointer to the target pointer (skipped if nearest is past target), then
// walks the target on from there, each read followed by a compare; the walk
// starts where the search ends, so there are at most 129 reads. A live
// target then runs cordic atan2 and a heading unwrap before done; a stopped
// route skips cordic and unwrap.
// opcode 1 (append) scans valid bits one per cycle for the first empty slot
// and writes it, or flags the table full. opcode 2 (clear) and opcode 3 give
// done in the cycle after the accepting edge. The next beat can be taken in
// the cycle after done. Reset clears the valid bits and both pointers and loads
// the lookahead radius with 16384; no memory sweep is needed. csr_valid/
// csr_ready write the lookahead radius; csr_ready is high whenever idle.

module lookahead_waypoint_tracker_top (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_opcode,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic signed [15:0] req_vehicle_heading,
   input  logic signed [23:0] req_wp_x,
   input  logic signed [23:0] req_wp_y,
   input  logic [15:0] req_wp_speed,
   output logic done,
   output logic [6:0] rsp_nearest_index,
   output logic [6:0] rsp_target_index,
   output logic [15:0] rsp_speed_command,
   output logic signed [15:0] rsp_bearing,
   output logic signed [16:0] rsp_unwrapped_heading,
   output logic rsp_stopped,
   output logic rsp_table_full,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [22:0] csr_data
);

   localparam int IW = lwt_pkg::IdxW;
   localparam logic [IW-1:0] LAST = IW'(lwt_pkg::TableDepth - 1);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_FREE   = 9'b000000010,
      S_NREAD  = 9'b000000100,
      S_NCMP   = 9'b000001000,
      S_TREAD  = 9'b000010000,
      S_TCMP   = 9'b000100000,
      S_CORDIC = 9'b001000000,
      S_WRAP   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // waypoint memory, one read/write port, registered read
   logic [63:0] mem [lwt_pkg::TableDepth];
   logic [63:0] rd_ff;
   logic [IW-1:0] addr;
   logic we;
   logic [63:0] wdata;
   logic [lwt_pkg::TableDepth-1:0] valid_ff;

   logic [22:0] look_ff;
   logic [IW-1:0] near_ff, near_in, targ_ff, targ_in, idx_ff, idx_in;
   logic [IW-1:0] best_ff, best_in;
   logic found_ff, found_in;
   logic [49:0] bestd_ff, bestd_in;
   logic signed [23:0] px_ff, py_ff, wx_ff, wy_ff;
   logic signed [15:0] hd_ff;
   logic [15:0] ws_ff, spd_ff, spd_in;
   logic full_ff, full_in, stop_ff, stop_in;
   logic signed [15:0] bear_ff, bear_in;
   logic signed [16:0] unw_ff, unw_in;
   logic signed [24:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [24:0] dx, dy;
   logic signed [49:0] dx2, dy2;
   logic [49:0] d2, l2;
   logic signed [18:0] err;
   lwt_pkg::cordic_req_type creq;
   lwt_pkg::cordic_rsp_type crsp;
   logic [15:0] rd_spd;

   assign dx = 25'(signed'(rd_ff[63:40])) - 25'(px_ff);
   assign dy = 25'(signed'(rd_ff[39:16])) - 25'(py_ff);
   assign rd_spd = rd_ff[15:0];
   assign dx2 = dx * dx;
   assign dy2 = dy * dy;
   assign d2 = unsigned'(dx2) + unsigned'(dy2);
   assign l2 = 50'(look_ff) * 50'(look_ff);

   // sequencer
   always_comb begin
      state_in = state_ff; near_in = near_ff; targ_in = targ_ff; idx_in = idx_ff;
      best_in = best_ff; found_in = found_ff; bestd_in = bestd_ff;
      spd_in = spd_ff; full_in = full_ff; stop_in = stop_ff;
      bear_in = bear_ff; unw_in = unw_ff; dx_in = dx_ff; dy_in = dy_ff;
      addr = idx_ff; we = 1'b0;
      wdata = {wx_ff, wy_ff, ws_ff};
      creq.start = 1'b0; creq.num = -dx_ff; creq.den = dy_ff;
      err = 19'(bear_ff) - 19'(hd_ff);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               spd_in = '0; full_in = 1'b0; stop_in = 1'b0;
               bear_in = '0; unw_in = '0;
               idx_in = '0;
               case (req_opcode)
                  lwt_pkg::OP_UPDATE: begin
                     idx_in = near_ff; best_in = near_ff; found_in = 1'b0;
                     state_in = (near_ff <= targ_ff) ? S_NREAD : S_TREAD;
                     if (near_ff > targ_ff) idx_in = targ_ff;
                  end
                  lwt_pkg::OP_APPEND: state_in = S_FREE;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_FREE: begin
            if (!valid_ff[idx_ff]) begin
               we = 1'b1; state_in = S_DONE;
            end else if (idx_ff == LAST) begin
               full_in = 1'b1; state_in = S_DONE;
            end else idx_in = idx_ff + 1'b1;
         end
         S_NREAD: state_in = S_NCMP;
         S_NCMP: begin
            // keep the speed of the best entry so far
            if (valid_ff[idx_ff] && (!found_ff || d2 < bestd_ff)) begin
               found_in = 1'b1; bestd_in = d2; best_in = idx_ff; spd_in = rd_spd;
            end
            if (idx_ff == targ_ff || idx_ff == LAST) begin
               near_in = (valid_ff[idx_ff] && (!found_ff || d2 < bestd_ff))
                         ? idx_ff : best_ff;
               idx_in = targ_ff; state_in = S_TREAD;
               // found flag is reused to fire the cordic start once
               found_in = 1'b0;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = S_NREAD;
            end
         end
         S_TREAD: state_in = S_TCMP;
         S_TCMP: begin
            if (idx_ff != LAST && valid_ff[idx_ff] && d2 < l2) begin
               idx_in = idx_ff + 1'b1; state_in = S_TREAD;
            end else begin
               targ_in = idx_ff;
               if (!valid_ff[idx_ff]) begin
                  spd_in = '0; stop_in = 1'b1; state_in = S_DONE;
               end else begin
                  dx_in = dx; dy_in = dy; state_in = S_CORDIC;
               end
            end
         end
         S_CORDIC: begin
            creq.start = !found_ff;
            found_in = 1'b1;
            if (crsp.done) begin
               bear_in = crsp.angle; state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            if (err > 19'(lwt_pkg::PI_Q13)) err = err - 19'(lwt_pkg::TWO_PI_Q13);
            else if (err <= -19'(lwt_pkg::PI_Q13)) err = err + 19'(lwt_pkg::TWO_PI_Q13);
            unw_in = 17'(19'(bear_ff) - err);
            state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; near_ff <= '0; targ_ff <= '0;
         look_ff <= 23'd16384;
      end else begin
         state_ff <= state_in; near_ff <= near_in; targ_ff <= targ_in;
         if (we) valid_ff[addr] <= 1'b1;
         if (state_ff == S_IDLE && start && req_opcode == lwt_pkg::OP_CLEAR)
            valid_ff <= '0;
         if (csr_valid && csr_ready) look_ff <= csr_data;
      end
      idx_ff <= idx_in; best_ff <= best_in; found_ff <= found_in; bestd_ff <= bestd_in;
      spd_ff <= spd_in; full_ff <= full_in; stop_ff <= stop_in;
      bear_ff <= bear_in; unw_ff <= unw_in; dx_ff <= dx_in; dy_ff <= dy_in;
      if (state_ff == S_IDLE && start) begin
         px_ff <= req_pos_x; py_ff <= req_pos_y;
         hd_ff <= req_vehicle_heading; wx_ff <= req_wp_x; wy_ff <= req_wp_y;
         ws_ff <= req_wp_speed;
      end
   end

   lwt_cordic u_cordic (.clock(clock), .reset(reset), .req(creq), .rsp(crsp));

   // result beat
   assign busy = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign done = (state_ff == S_DONE);
   assign rsp_nearest_index = 7'(near_ff);
   assign rsp_target_index = 7'(targ_ff);
   assign rsp_speed_command = spd_ff;
   assign rsp_bearing = bear_ff;
   assign rsp_unwrapped_heading = unw_ff;
   assign rsp_stopped = stop_ff;
   assign rsp_table_full = full_ff;

   `LWT_ASSERT_IMPL(a_done_busy, clock, reset, done, busy)
   `LWT_ASSERT_IMPL(a_stop_nobear, clock, reset, done && rsp_stopped,
      rsp_bearing == 16'sd0 && rsp_speed_command == 16'd0)
   `LWT_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)

endmodule

### hw/rtl/lwt_cordic.sv
// iterative cordic atan2(num, den), one micro-rotation per cycle
// depends on lwt_pkg
`timescale 1ns / 1ps
`include "lookahead_waypoint_tracker_top_defines.svh"

module lwt_cordic (
   input  logic clock,
   input  logic reset,
   input  lwt_pkg::cordic_req_type req,
   output lwt_pkg::cordic_rsp_type rsp
);

   logic signed [31:0] a_ff, a_in, b_ff, b_in;
   logic signed [23:0] z_ff, z_in;
   logic [lwt_pkg::StepW-1:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic signed [15:0] ang_ff, ang_in;
   logic signed [31:0] sa, sb;
   logic signed [24:0] zr;
   logic signed [17:0] zq;
   logic signed [24:0] pa, pb;

   // pre-rotation, iteration and rounding
   always_comb begin
      a_in = a_ff; b_in = b_ff; z_in = z_ff; step_in = step_ff;
      busy_in = busy_ff; done_in = 1'b0; ang_in = ang_ff;
      sa = a_ff >>> step_ff;
      sb = b_ff >>> step_ff;
      pa = req.den; pb = req.num;
      zr = (25'(z_ff) + 25'sd64) >>> 7;
      zq = zr[17:0];
      if (req.start) begin
         if (req.den == 25'sd0 && req.num == 25'sd0) begin
            ang_in = 16'sd0; done_in = 1'b1;
         end else begin
            z_in = 24'sd0;
            if (req.den < 0) begin
               z_in = (req.num >= 0) ? lwt_pkg::PI_Q20 : -lwt_pkg::PI_Q20;
               pa = -req.den; pb = -req.num;
            end
            a_in = {{3{pa[24]}}, pa, 4'b0};
            b_in = {{3{pb[24]}}, pb, 4'b0};
            step_in = '0; busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (b_ff > 0) begin
            a_in = a_ff + sb; b_in = b_ff - sa;
            z_in = z_ff + lwt_pkg::atan_q20(step_ff);
         end else begin
            a_in = a_ff - sb; b_in = b_ff + sa;
            z_in = z_ff - lwt_pkg::atan_q20(step_ff);
         end
         // the step count parks on the last step so the rounding pass can see it
         if (step_ff == lwt_pkg::StepW'(lwt_pkg::CordicSteps - 1)) busy_in = 1'b0;
         else step_in = step_ff + 1'b1;
      end else if (!done_ff && step_ff == lwt_pkg::StepW'(lwt_pkg::CordicSteps - 1)
                   && a_ff != 32'sd0) begin
         // final rounding and clamp
         if (zq > lwt_pkg::PI_Q13) ang_in = 16'sd25736;
         else if (zq < -lwt_pkg::PI_Q13) ang_in = -16'sd25736;
         else ang_in = zq[15:0];
         done_in = 1'b1;
         a_in = 32'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; step_ff <= '0; a_ff <= 32'sd0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; step_ff <= step_in; a_ff <= a_in;
      end
      b_ff <= b_in; z_ff <= z_in; ang_ff <= ang_in;
   end

   assign rsp.done = done_ff;
   assign rsp.angle = ang_ff;

   `LWT_ASSERT_NEXT(a_start_busy, clock, reset,
      req.start && !(req.den == 25'sd0 && req.num == 25'sd0), busy_ff)
   `LWT_ASSERT_IMPL(a_no_done_busy, clock, reset, busy_ff, !done_ff)
   `LWT_ASSERT_IMPL(a_clamp, clock, reset, done_ff,
      ang_ff <= 16'sd25736 && ang_ff >= -16'sd25736)

endmodule
